>>> hw/rtl/hnft_pkg.sv
package hnft_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_FLAG  = 2'd1,
        OP_DATA  = 2'd2,
        OP_FCS   = 2'd3
    } hnft_op_t;

    localparam int unsigned CRC_W     = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_W     = 5;   // holds up to CRC_W bits per transaction
    localparam int unsigned ONES_W    = 3;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h8408;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;

    localparam logic [CNT_W-1:0]  CNT_BYTE  = 5'd8;
    localparam logic [CNT_W-1:0]  CNT_FCS   = 5'd16;

    localparam logic [ONES_W-1:0] ONES_STUFF = 3'd5;
    localparam logic [ONES_W-1:0] ONES_MAX   = 3'd7;

    // Load command from the input side into the serializer
    typedef struct packed {
        logic             valid;
        logic             start;
        logic             stuff_en;
        logic             crc_en;
        logic [CNT_W-1:0] count;
        logic [CRC_W-1:0] bits;
    } hnft_load_t;

    // Bit-serial CRC update request
    typedef struct packed {
        logic shift;
        logic bit_in;
    } hnft_crc_ctl_t;

endpackage

>>> hw/rtl/hnft_crc.sv
module hnft_crc (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  init,
    input  hnft_pkg::hnft_crc_ctl_t ctl,
    output logic [15:0]           crc
);
    import hnft_pkg::*;

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic             fb;

    // Reflected CRC-16/X.25, one bit per cycle while ctl.shift is set
    always_comb begin
        fb       = crc_reg[0] ^ ctl.bit_in;
        crc_next = crc_reg;
        if (init) begin
            crc_next = CRC_INIT;
        end else if (ctl.shift) begin
            crc_next = (crc_reg >> 1) ^ (fb ? CRC_POLY : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

>>> hw/rtl/hnft_serializer.sv
module hnft_serializer (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  hnft_pkg::hnft_load_t    load,
    output logic                    busy,
    output hnft_pkg::hnft_crc_ctl_t crc_ctl,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_line_bit,
    output logic                    m_stuffed,
    output logic                    m_last
);
    import hnft_pkg::*;

    logic [CRC_W-1:0]  shreg_reg, shreg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              stuff_pend_reg, stuff_pend_next;
    logic              stuff_en_reg, stuff_en_next;
    logic              crc_en_reg, crc_en_next;
    logic [ONES_W-1:0] ones_reg, ones_next;
    logic              level_reg, level_next;
    logic              valid_reg, valid_next;
    logic              line_reg, line_next;
    logic              stuffed_reg, stuffed_next;
    logic              last_reg, last_next;
    logic              out_free;
    logic              emit;

    assign busy     = (cnt_reg != '0) || stuff_pend_reg;
    assign out_free = !valid_reg || m_ready;
    assign emit     = busy && out_free;

    assign crc_ctl.shift  = emit && !stuff_pend_reg && crc_en_reg;
    assign crc_ctl.bit_in = shreg_reg[0];

    always_comb begin
        shreg_next      = shreg_reg;
        cnt_next        = cnt_reg;
        stuff_pend_next = stuff_pend_reg;
        stuff_en_next   = stuff_en_reg;
        crc_en_next     = crc_en_reg;
        ones_next       = ones_reg;
        level_next      = level_reg;
        valid_next      = out_free ? 1'b0 : valid_reg;
        line_next       = line_reg;
        stuffed_next    = stuffed_reg;
        last_next       = last_reg;

        if (load.valid) begin
            if (load.start) begin
                level_next = 1'b1;
                ones_next  = '0;
            end else begin
                shreg_next    = load.bits;
                cnt_next      = load.count;
                stuff_en_next = load.stuff_en;
                crc_en_next   = load.crc_en;
            end
        end else if (emit) begin
            valid_next = 1'b1;
            if (stuff_pend_reg) begin
                // inserted zero: toggle the line, clear the run
                level_next      = !level_reg;
                ones_next       = '0;
                stuff_pend_next = 1'b0;
                line_next       = !level_reg;
                stuffed_next    = 1'b1;
                last_next       = (cnt_reg == '0);
            end else begin
                if (!shreg_reg[0]) begin
                    level_next = !level_reg;
                    ones_next  = '0;
                end else begin
                    ones_next = (ones_reg == ONES_MAX) ? ONES_MAX : ones_reg + 1'b1;
                end
                stuff_pend_next = stuff_en_reg && shreg_reg[0] && (ones_next == ONES_STUFF);
                shreg_next      = shreg_reg >> 1;
                cnt_next        = cnt_reg - 1'b1;
                line_next       = level_next;
                stuffed_next    = 1'b0;
                last_next       = (cnt_reg == CNT_W'(1)) && !stuff_pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            stuff_pend_reg <= 1'b0;
            stuff_en_reg   <= 1'b0;
            crc_en_reg     <= 1'b0;
            ones_reg       <= '0;
            level_reg      <= 1'b1;
            valid_reg      <= 1'b0;
        end else begin
            cnt_reg        <= cnt_next;
            stuff_pend_reg <= stuff_pend_next;
            stuff_en_reg   <= stuff_en_next;
            crc_en_reg     <= crc_en_next;
            ones_reg       <= ones_next;
            level_reg      <= level_next;
            valid_reg      <= valid_next;
        end
        shreg_reg   <= shreg_next;
        line_reg    <= line_next;
        stuffed_reg <= stuffed_next;
        last_reg    <= last_next;
    end

    assign m_valid    = valid_reg;
    assign m_line_bit = line_reg;
    assign m_stuffed  = stuffed_reg;
    assign m_last     = last_reg;

    // A pending stuff zero follows exactly five ones of a stuffed transaction
    a_stuff_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        stuff_pend_reg |-> (stuff_en_reg && ones_reg == ONES_STUFF))
        else $error("stuff zero pending without a run of five ones");

    // Stuffing keeps the run of ones short while a stuffed transaction is sent
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy && stuff_en_reg) |-> (ones_reg <= ONES_STUFF))
        else $error("run of ones too long in stuffed transaction");

    // A load that sends bits makes the serializer busy on the next cycle
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (load.valid && !load.start && load.count != '0) |=> busy)
        else $error("loaded bits not taken up");

    // A load arrives only while the serializer is idle
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load.valid |-> !busy)
        else $error("load while bits still pending");

endmodule

>>> hw/rtl/hdlc_nrzi_frame_transmitter_unit.sv
// Channel | Ports             | Contents (lowest bit first)
// --------+-------------------+----------------------------------------------
// input   | s_tvalid/s_tready | s_tdata: data_byte[7:0]; s_tuser: operation[1:0]
// output  | m_tvalid/m_tready | m_tdata: line_bit, 7 zero bits; m_tuser: stuffed;
//         |                   | m_tlast: last bit time of the input transaction
//
// One line bit leaves per cycle from the bit-serial shifter while m_tready allows;
// an input transaction is accepted, then its line bits, inserted stuff zeros included,
// leave one by one. The CRC advances one bit per cycle with the shifter, on data bits only.
// aresetn is synchronous, active low: line high, CRC 0xFFFF, run count zero.
// A stalled m_tready holds the output register and the shifter; s_tready drops
// while bits of the current transaction remain, not while a result only waits.
module hdlc_nrzi_frame_transmitter_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] line_bit, [7:1] zero
    output logic       m_tuser,   // [0] stuffed
    output logic       m_tlast
);
    import hnft_pkg::*;

    hnft_load_t    load;
    hnft_crc_ctl_t crc_ctl;
    hnft_op_t      op;
    logic          busy;
    logic          accept;
    logic          line_bit;
    logic [CRC_W-1:0] crc;

    // Take a new transaction only once the shifter has drained
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;
    assign op       = hnft_op_t'(s_tuser);

    // Decode the operation into a shifter load
    always_comb begin
        load          = '0;
        load.valid    = accept;
        unique case (op)
            OP_START: begin
                load.start = 1'b1;
            end
            OP_FLAG: begin
                load.count = CNT_BYTE;
                load.bits  = {{(CRC_W-BYTE_W){1'b0}}, FLAG_BYTE};
            end
            OP_DATA: begin
                load.stuff_en = 1'b1;
                load.crc_en   = 1'b1;
                load.count    = CNT_BYTE;
                load.bits     = {{(CRC_W-BYTE_W){1'b0}}, s_tdata};
            end
            OP_FCS: begin
                // complemented CRC, low byte first
                load.stuff_en = 1'b1;
                load.count    = CNT_FCS;
                load.bits     = ~crc;
            end
            default: begin
                load.start = 1'b0;
            end
        endcase
    end

    hnft_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .init    (accept && op == OP_START),
        .ctl     (crc_ctl),
        .crc     (crc)
    );

    hnft_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .busy       (busy),
        .crc_ctl    (crc_ctl),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_line_bit (line_bit),
        .m_stuffed  (m_tuser),
        .m_last     (m_tlast)
    );

    assign m_tdata = {7'd0, line_bit};

endmodule
